// ===== hdl/bmp_24bit_stream_decoder_macros.svh =====
// bmp_24bit_stream_decoder_macros.svh
// Assertion helpers for the bitmap stream decoder; expects clk and rst_n in scope.
`ifndef BMP_24BIT_STREAM_DECODER_MACROS_SVH
`define BMP_24BIT_STREAM_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define BMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMP_ASSERT_IMP(lbl, ante, cons, msg)
`define BMP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/bmp24_pkg.sv =====
// bmp24_pkg.sv
// Shared types, codes and header constants for the bitmap stream decoder.
// No dependencies.
package bmp24_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [31:0] HDR_INFO     = 32'd40;
  localparam logic [31:0] HDR_CORE     = 32'd12;
  localparam logic [31:0] HDR_V2       = 32'd64;
  localparam logic [31:0] HDR_V4       = 32'd108;
  localparam logic [31:0] HDR_V5       = 32'd124;
  localparam logic [31:0] FILE_HDR_LEN = 32'd14;
  localparam logic [15:0] BPP_24       = 16'd24;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_V3,
    PH_CORE,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SIG     = 3'd0,
    ERR_BPP     = 3'd1,
    ERR_COMP    = 3'd2,
    ERR_UNSUP   = 3'd3,
    ERR_UNKNOWN = 3'd4,
    ERR_OFFSET  = 3'd5,
    ERR_DIM     = 3'd6
  } err_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       sof;
  } beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    err_t        error_code;
    logic        last_pixel;
  } result_t;

endpackage

// ===== hdl/bmp24_in_stage.sv =====
// bmp24_in_stage.sv
// Input register of the decoder: holds one byte beat until the parser takes it.
// Depends on bmp24_pkg.
module bmp24_in_stage import bmp24_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_file,
  input  logic       advance,
  output beat_t      beat
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       sof_r;
  logic       accept;

  assign in_stall  = valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data_byte;
      sof_r  <= in_start_of_file;
    end
  end

  assign beat = '{valid: valid_r, data: data_r, sof: sof_r};

endmodule

// ===== hdl/bmp24_parser.sv =====
// bmp24_parser.sv
// Per-byte parser: header fields, checks, pixel assembly and row padding.
// Depends on bmp24_pkg and bmp_24bit_stream_decoder_macros.svh.
`include "bmp_24bit_stream_decoder_macros.svh"

module bmp24_parser import bmp24_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  beat_t   beat,
  input  logic    slot_free,
  output logic    advance,
  output logic    push,
  output result_t res
);

  localparam int DW = $clog2(MAX_DIM + 1);

  localparam logic [31:0] POS_SIG    = 32'd1;
  localparam logic [31:0] POS_OFFSET = 32'd13;
  localparam logic [31:0] POS_HLEN   = 32'd17;
  localparam logic [31:0] POS_V3_W   = 32'd21;
  localparam logic [31:0] POS_V3_H   = 32'd25;
  localparam logic [31:0] POS_V3_BPP = 32'd29;
  localparam logic [31:0] POS_V3_CMP = 32'd33;
  localparam logic [31:0] POS_CR_W   = 32'd19;
  localparam logic [31:0] POS_CR_H   = 32'd21;
  localparam logic [31:0] POS_CR_BPP = 32'd25;

  // state registers
  phase_t          phase_r, phase_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic [31:0]     fa_r, fa_nxt;
  logic [31:0]     off_r, off_nxt;
  logic            core_r, core_nxt;
  logic [DW-1:0]   w_r, w_nxt, h_r, h_nxt;
  logic            wok_r, wok_nxt, hok_r, hok_nxt;
  logic [DW-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic [1:0]      comp_r, comp_nxt;
  logic [1:0]      pad_r, pad_nxt;
  logic [15:0]     held_r, held_nxt;

  // state as seen by this beat (start of file restarts it)
  phase_t          phase_b;
  logic [31:0]     pos_b, fa_b, off_b;
  logic            core_b, wok_b, hok_b;
  logic [DW-1:0]   w_b, h_b, col_b, row_b;
  logic [1:0]      comp_b, pad_b;
  logic [15:0]     held_b;

  // decode flags
  logic            err_hit, err_any, fin_hit, fin_bad, hdr_ok;
  err_t            err_code, err_final;
  logic            go_v3, go_core, take, px_emit, px_last, row_wrap, pad_end;
  logic [31:0]     dim_sel, hdr_min, w_ext, h_ext, col_ext, row_ext;
  logic            dim_ok;
  logic [DW:0]     col_inc, row_inc;
  logic            res_hit;

  always_comb begin
    if (beat.sof) begin
      phase_b = PH_HEAD;
      pos_b   = '0;
      fa_b    = '0;
      off_b   = '0;
      core_b  = 1'b0;
      w_b     = '0;
      h_b     = '0;
      wok_b   = 1'b0;
      hok_b   = 1'b0;
      col_b   = '0;
      row_b   = '0;
      comp_b  = '0;
      pad_b   = '0;
      held_b  = '0;
    end else begin
      phase_b = phase_r;
      pos_b   = pos_r;
      fa_b    = fa_r;
      off_b   = off_r;
      core_b  = core_r;
      w_b     = w_r;
      h_b     = h_r;
      wok_b   = wok_r;
      hok_b   = hok_r;
      col_b   = col_r;
      row_b   = row_r;
      comp_b  = comp_r;
      pad_b   = pad_r;
      held_b  = held_r;
    end
  end

  assign w_ext   = 32'(w_b);
  assign h_ext   = 32'(h_b);
  assign col_ext = 32'(col_b);
  assign row_ext = 32'(row_b);
  assign col_inc = {1'b0, col_b} + (DW+1)'(1);
  assign row_inc = {1'b0, row_b} + (DW+1)'(1);
  assign dim_ok  = (dim_sel != 32'd0) && (dim_sel <= 32'(MAX_DIM));
  assign hdr_min = (core_b ? HDR_CORE : HDR_INFO) + FILE_HDR_LEN;

  // field decode and datapath updates
  always_comb begin
    pos_nxt  = (pos_b != '1) ? pos_b + 32'd1 : pos_b;
    fa_nxt   = {beat.data, fa_b[31:8]};
    off_nxt  = off_b;
    core_nxt = core_b;
    w_nxt    = w_b;
    h_nxt    = h_b;
    wok_nxt  = wok_b;
    hok_nxt  = hok_b;
    col_nxt  = col_b;
    row_nxt  = row_b;
    comp_nxt = comp_b;
    pad_nxt  = pad_b;
    held_nxt = held_b;
    err_hit  = 1'b0;
    err_code = ERR_SIG;
    fin_hit  = 1'b0;
    go_v3    = 1'b0;
    go_core  = 1'b0;
    take     = 1'b0;
    pad_end  = 1'b0;
    px_emit  = 1'b0;
    px_last  = 1'b0;
    row_wrap = 1'b0;
    dim_sel  = (phase_b == PH_CORE) ? {16'd0, fa_nxt[31:16]} : fa_nxt;

    case (phase_b)
      PH_HEAD: begin
        if (pos_b == POS_SIG) begin
          if (fa_nxt[31:16] != {SIG_M, SIG_B}) begin
            err_hit  = 1'b1;
            err_code = ERR_SIG;
          end
        end else if (pos_b == POS_OFFSET) begin
          off_nxt = fa_nxt;
        end else if (pos_b == POS_HLEN) begin
          if (fa_nxt == HDR_INFO) begin
            go_v3    = 1'b1;
            core_nxt = 1'b0;
          end else if (fa_nxt == HDR_CORE) begin
            go_core  = 1'b1;
            core_nxt = 1'b1;
          end else if (fa_nxt == HDR_V2 || fa_nxt == HDR_V4 || fa_nxt == HDR_V5) begin
            err_hit  = 1'b1;
            err_code = ERR_UNSUP;
          end else begin
            err_hit  = 1'b1;
            err_code = ERR_UNKNOWN;
          end
        end
      end
      PH_V3: begin
        if (pos_b == POS_V3_W) begin
          w_nxt   = dim_sel[DW-1:0];
          wok_nxt = dim_ok;
        end else if (pos_b == POS_V3_H) begin
          h_nxt   = dim_sel[DW-1:0];
          hok_nxt = dim_ok;
        end else if (pos_b == POS_V3_BPP) begin
          if (fa_nxt[31:16] != BPP_24) begin
            err_hit  = 1'b1;
            err_code = ERR_BPP;
          end
        end else if (pos_b == POS_V3_CMP) begin
          if (fa_nxt != 32'd0) begin
            err_hit  = 1'b1;
            err_code = ERR_COMP;
          end else begin
            fin_hit = 1'b1;
          end
        end
      end
      PH_CORE: begin
        if (pos_b == POS_CR_W) begin
          w_nxt   = dim_sel[DW-1:0];
          wok_nxt = dim_ok;
        end else if (pos_b == POS_CR_H) begin
          h_nxt   = dim_sel[DW-1:0];
          hok_nxt = dim_ok;
        end else if (pos_b == POS_CR_BPP) begin
          if (fa_nxt[31:16] != BPP_24) begin
            err_hit  = 1'b1;
            err_code = ERR_BPP;
          end else begin
            fin_hit = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        take = (pos_b >= off_b);
      end
      PH_PIXEL: begin
        take = 1'b1;
      end
      PH_PAD: begin
        pad_nxt = pad_b - 2'd1;
        pad_end = (pad_nxt == 2'd0);
      end
      default: begin
      end
    endcase

    // assemble B, G, R; emit on the third byte
    if (take) begin
      case (comp_b)
        2'd0: begin
          held_nxt = {8'd0, beat.data};
          comp_nxt = 2'd1;
        end
        2'd1: begin
          held_nxt = {beat.data, held_b[7:0]};
          comp_nxt = 2'd2;
        end
        default: begin
          comp_nxt = 2'd0;
          px_emit  = 1'b1;
          px_last  = (row_inc == {1'b0, h_b}) && (col_inc == {1'b0, w_b});
          if (!px_last) begin
            if (col_inc >= {1'b0, w_b}) begin
              row_wrap = 1'b1;
              col_nxt  = '0;
              row_nxt  = row_inc[DW-1:0];
              // 3*width mod 4 leaves exactly width mod 4 pad bytes
              pad_nxt  = w_ext[1:0];
            end else begin
              col_nxt = col_inc[DW-1:0];
            end
          end
        end
      endcase
    end
  end

  assign fin_bad   = !(wok_b && hok_b) || (off_b < hdr_min);
  assign hdr_ok    = fin_hit && !fin_bad;
  assign err_any   = err_hit || (fin_hit && fin_bad);
  assign err_final = err_hit ? err_code : (!(wok_b && hok_b) ? ERR_DIM : ERR_OFFSET);

  // next phase
  always_comb begin
    phase_nxt = phase_b;
    if (err_any) begin
      phase_nxt = PH_ERROR;
    end else if (hdr_ok) begin
      phase_nxt = PH_SKIP;
    end else begin
      case (phase_b)
        PH_HEAD: begin
          if (go_v3) begin
            phase_nxt = PH_V3;
          end else if (go_core) begin
            phase_nxt = PH_CORE;
          end
        end
        PH_SKIP: begin
          if (take) begin
            phase_nxt = PH_PIXEL;
          end
        end
        PH_PAD: begin
          if (pad_end) begin
            phase_nxt = PH_PIXEL;
          end
        end
        default: begin
        end
      endcase
      if (px_emit) begin
        if (px_last) begin
          phase_nxt = PH_DONE;
        end else if (row_wrap && w_ext[1:0] != 2'd0) begin
          phase_nxt = PH_PAD;
        end
      end
    end
  end

  // result
  always_comb begin
    res     = '0;
    res_hit = 1'b0;
    if (err_any) begin
      res_hit        = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = err_final;
    end else if (hdr_ok) begin
      res_hit          = 1'b1;
      res.kind         = KIND_HEADER;
      res.image_width  = w_ext[12:0];
      res.image_height = h_ext[12:0];
    end else if (px_emit) begin
      res_hit          = 1'b1;
      res.kind         = KIND_PIXEL;
      res.red          = beat.data;
      res.green        = held_b[15:8];
      res.blue         = held_b[7:0];
      res.column       = col_ext[11:0];
      res.row          = row_ext[11:0];
      res.image_width  = w_ext[12:0];
      res.image_height = h_ext[12:0];
      res.last_pixel   = px_last;
    end
  end

  // hold the beat only when it has a result and the output slot is full
  assign advance = beat.valid && (slot_free || !res_hit);
  assign push    = advance && res_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      pos_r   <= '0;
      fa_r    <= '0;
      off_r   <= '0;
      core_r  <= 1'b0;
      w_r     <= '0;
      h_r     <= '0;
      wok_r   <= 1'b0;
      hok_r   <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      comp_r  <= '0;
      pad_r   <= '0;
      held_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      fa_r    <= fa_nxt;
      off_r   <= off_nxt;
      core_r  <= core_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      wok_r   <= wok_nxt;
      hok_r   <= hok_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      comp_r  <= comp_nxt;
      pad_r   <= pad_nxt;
      held_r  <= held_nxt;
    end
  end

  `BMP_ASSERT_IMP(a_error_silent, advance && phase_b == PH_ERROR, !res_hit, "result after error")
  `BMP_ASSERT_NXT(a_last_done, push && res.last_pixel, phase_r == PH_DONE, "no done after last")
  `BMP_ASSERT_IMP(a_col_range, res_hit && res.kind == KIND_PIXEL, col_b < w_b, "column past width")
  `BMP_ASSERT_IMP(a_pad_live, phase_r == PH_PAD, pad_r != 2'd0, "pad phase with no pad left")

endmodule

// ===== hdl/bmp24_out_stage.sv =====
// bmp24_out_stage.sv
// Result register: holds one result beat until the sink takes it.
// Depends on bmp24_pkg.
module bmp24_out_stage import bmp24_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res,
  output logic    slot_free
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign slot_free = !valid_r || !out_stall;
  assign valid_nxt = push || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/bmp_24bit_stream_decoder.sv =====
// Bitmap stream decoder, one file byte per beat. Checks the BM signature, reads the data
// offset and a 40-byte or 12-byte header, issues one header result (or one error result),
// skips to the pixel data and issues one pixel result per B,G,R byte triple with its
// column and row, bottom row first, dropping row padding. A byte is taken every cycle
// unless the input stalls: the parser's state update for one byte is combinational
// between the input register and the result register, and the input stalls only while
// a finished result waits in the full result register and the held byte would produce
// another. Assert start_of_file on byte 0 of each file.
// Depends on bmp24_pkg, bmp24_in_stage, bmp24_parser and bmp24_out_stage.
module bmp_24bit_stream_decoder import bmp24_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic [2:0]  out_error_code,
  output logic        out_last_pixel
);

  beat_t   beat;
  logic    advance;
  logic    push;
  logic    slot_free;
  result_t res;
  result_t out_res;

  bmp24_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .advance          (advance),
    .beat             (beat)
  );

  bmp24_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .slot_free (slot_free),
    .advance   (advance),
    .push      (push),
    .res       (res)
  );

  bmp24_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .slot_free (slot_free)
  );

  assign out_kind         = out_res.kind;
  assign out_red          = out_res.red;
  assign out_green        = out_res.green;
  assign out_blue         = out_res.blue;
  assign out_column       = out_res.column;
  assign out_row          = out_res.row;
  assign out_image_width  = out_res.image_width;
  assign out_image_height = out_res.image_height;
  assign out_error_code   = out_res.error_code;
  assign out_last_pixel   = out_res.last_pixel;

endmodule

// ===== verif/tb_bmp_24bit_stream_decoder.sv =====
// tb_bmp_24bit_stream_decoder.sv
// Self-checking bench for the bitmap stream decoder: byte-level parser model, directed
// table, random files of every header flavor. Depends on bmp24_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_bmp_24bit_stream_decoder;
  import bmp24_pkg::*;

  localparam int DIM_LIMIT   = MAX_DIM_DEF;
  localparam int ITEM_TARGET = 750;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    SC_GOOD_INFO, SC_GOOD_CORE, SC_BAD_SIG, SC_BAD_BPP, SC_BAD_COMP,
    SC_HDR_UNSUP, SC_HDR_UNKNOWN, SC_BAD_OFFSET, SC_BAD_DIM, SC_NOISE
  } scenario_t;

  typedef struct {
    logic [7:0] data;
    logic       sof;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_start_of_file;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic [12:0] out_image_width;
  logic [12:0] out_image_height;
  logic [2:0]  out_error_code;
  logic        out_last_pixel;

  // table row that travels with the byte on the input; -1 for random traffic
  int          in_row;

  result_t     pending_results[$];
  stim_row_t   dir_rows[$];
  logic [7:0]  file_bytes[$];
  int          fail_cnt   = 0;
  int          live_bytes = 0;
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  bit          long_hold  = 1'b0;

  // parser state of the model
  phase_t      prs_phase;
  logic [31:0] prs_pos, prs_shift, prs_data_ofs, prs_hdr_len;
  logic [31:0] prs_width, prs_height, prs_col, prs_row;
  logic [1:0]  prs_comp, prs_pad;
  logic [15:0] prs_bg;

  bmp_24bit_stream_decoder #(.MAX_DIM(DIM_LIMIT)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_error_code   (out_error_code),
    .out_last_pixel   (out_last_pixel)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void parser_clear();
    prs_phase    = PH_HEAD;
    prs_pos      = '0;
    prs_shift    = '0;
    prs_data_ofs = '0;
    prs_hdr_len  = '0;
    prs_width    = '0;
    prs_height   = '0;
    prs_col      = '0;
    prs_row      = '0;
    prs_comp     = '0;
    prs_pad      = '0;
    prs_bg       = '0;
  endfunction

  function automatic result_t error_beat(err_t code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic bit raise_error(err_t code, output result_t r);
    r         = error_beat(code);
    prs_phase = PH_ERROR;
    return 1'b1;
  endfunction

  function automatic bit close_header(output result_t r);
    if (prs_width < 32'd1 || prs_width > 32'(DIM_LIMIT) ||
        prs_height < 32'd1 || prs_height > 32'(DIM_LIMIT))
      return raise_error(ERR_DIM, r);
    if ({32'd0, prs_data_ofs} < 64'(FILE_HDR_LEN) + 64'(prs_hdr_len))
      return raise_error(ERR_OFFSET, r);
    r              = '0;
    r.kind         = KIND_HEADER;
    r.image_width  = prs_width[12:0];
    r.image_height = prs_height[12:0];
    prs_phase      = PH_SKIP;
    return 1'b1;
  endfunction

  function automatic bit take_pixel(logic [7:0] b, output result_t r);
    logic last;
    r = '0;
    if (prs_comp == 2'd0) begin
      prs_bg   = {8'h00, b};
      prs_comp = 2'd1;
      return 1'b0;
    end
    if (prs_comp == 2'd1) begin
      prs_bg   = {b, prs_bg[7:0]};
      prs_comp = 2'd2;
      return 1'b0;
    end
    prs_comp       = 2'd0;
    last           = (prs_row + 32'd1 == prs_height) && (prs_col + 32'd1 == prs_width);
    r.kind         = KIND_PIXEL;
    r.red          = b;
    r.green        = prs_bg[15:8];
    r.blue         = prs_bg[7:0];
    r.column       = prs_col[11:0];
    r.row          = prs_row[11:0];
    r.image_width  = prs_width[12:0];
    r.image_height = prs_height[12:0];
    r.last_pixel   = last;
    if (last) begin
      prs_phase = PH_DONE;
      return 1'b1;
    end
    prs_col++;
    if (prs_col >= prs_width) begin
      prs_col = '0;
      prs_row++;
      prs_pad = 2'((32'd4 - ((prs_width * 32'd3) & 32'd3)) & 32'd3);
      if (prs_pad != 2'd0) prs_phase = PH_PAD;
    end
    return 1'b1;
  endfunction

  // Advance the parser by one file byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(logic [7:0] b, logic sof, output result_t r);
    logic [31:0] p;
    r = '0;
    if (sof) parser_clear();
    p = prs_pos;
    if (prs_pos != 32'hFFFF_FFFF) prs_pos++;
    prs_shift = {b, prs_shift[31:8]};
    case (prs_phase)
      PH_HEAD: begin
        if (p == 32'd1) begin
          if (prs_shift[31:16] != {SIG_M, SIG_B}) return raise_error(ERR_SIG, r);
        end else if (p == 32'd13) begin
          prs_data_ofs = prs_shift;
        end else if (p == 32'd17) begin
          prs_hdr_len = prs_shift;
          if (prs_hdr_len == HDR_INFO) prs_phase = PH_V3;
          else if (prs_hdr_len == HDR_CORE) prs_phase = PH_CORE;
          else if (prs_hdr_len == HDR_V2 || prs_hdr_len == HDR_V4 || prs_hdr_len == HDR_V5)
            return raise_error(ERR_UNSUP, r);
          else return raise_error(ERR_UNKNOWN, r);
        end
        return 1'b0;
      end
      PH_V3: begin
        if (p == 32'd21) prs_width = prs_shift;
        else if (p == 32'd25) prs_height = prs_shift;
        else if (p == 32'd29) begin
          if (prs_shift[31:16] != BPP_24) return raise_error(ERR_BPP, r);
        end else if (p == 32'd33) begin
          if (prs_shift != 32'd0) return raise_error(ERR_COMP, r);
          return close_header(r);
        end
        return 1'b0;
      end
      PH_CORE: begin
        if (p == 32'd19) prs_width = {16'd0, prs_shift[31:16]};
        else if (p == 32'd21) prs_height = {16'd0, prs_shift[31:16]};
        else if (p == 32'd25) begin
          if (prs_shift[31:16] != BPP_24) return raise_error(ERR_BPP, r);
          return close_header(r);
        end
        return 1'b0;
      end
      PH_SKIP: begin
        if (p < prs_data_ofs) return 1'b0;
        prs_phase = PH_PIXEL;
        return take_pixel(b, r);
      end
      PH_PIXEL: return take_pixel(b, r);
      PH_PAD: begin
        prs_pad = prs_pad - 2'd1;
        if (prs_pad == 2'd0) prs_phase = PH_PIXEL;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_result(result_t want);
    if (out_kind !== want.kind) begin
      fail_cnt++;
      $error("kind: expected %0d, got %0d", want.kind, out_kind);
    end
    if (out_red !== want.red) begin
      fail_cnt++;
      $error("red: expected %0d, got %0d", want.red, out_red);
    end
    if (out_green !== want.green) begin
      fail_cnt++;
      $error("green: expected %0d, got %0d", want.green, out_green);
    end
    if (out_blue !== want.blue) begin
      fail_cnt++;
      $error("blue: expected %0d, got %0d", want.blue, out_blue);
    end
    if (out_column !== want.column) begin
      fail_cnt++;
      $error("column: expected %0d, got %0d", want.column, out_column);
    end
    if (out_row !== want.row) begin
      fail_cnt++;
      $error("row: expected %0d, got %0d", want.row, out_row);
    end
    if (out_image_width !== want.image_width) begin
      fail_cnt++;
      $error("image_width: expected %0d, got %0d", want.image_width, out_image_width);
    end
    if (out_image_height !== want.image_height) begin
      fail_cnt++;
      $error("image_height: expected %0d, got %0d", want.image_height, out_image_height);
    end
    if (out_error_code !== want.error_code) begin
      fail_cnt++;
      $error("error_code: expected %0d, got %0d", want.error_code, out_error_code);
    end
    if (out_last_pixel !== want.last_pixel) begin
      fail_cnt++;
      $error("last_pixel: expected %0d, got %0d", want.last_pixel, out_last_pixel);
    end
  endfunction

  // Pop the result side first so a new expectation never overtakes an older one.
  always @(posedge clk) begin : scoreboard
    result_t pred;
    bit      got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          fail_cnt++;
          $error("unexpected result beat: kind %0d", out_kind);
        end else begin
          check_result(pending_results.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        if (in_start_of_file || !(prs_phase inside {PH_ERROR, PH_DONE})) live_bytes++;
        got = decode_byte(in_data_byte, in_start_of_file, pred);
        if (in_row >= 0 && dir_rows[in_row].typed) pending_results.push_back(dir_rows[in_row].want);
        else if (got) pending_results.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[bmp_24bit_stream_decoder] ERROR");
      $finish;
    end
  end

  // Receiver: stretches of free flow, random and patterned stalls, one long hold-off.
  initial begin : rx_pacing
    int span, pick, k;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      pick = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      for (k = 0; k < span; k++) begin
        if (pick == 0) out_stall <= 1'b0;
        else if (pick == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else if (pick == 2) out_stall <= ($urandom_range(0, 1) == 1);
        else out_stall <= (k % 4 != 0);
        @(posedge clk);
      end
    end
  end

  function automatic void add_row(logic [7:0] d, logic s, bit t = 1'b0, result_t w = '0);
    stim_row_t row_e;
    row_e.data  = d;
    row_e.sof   = s;
    row_e.typed = t;
    row_e.want  = w;
    dir_rows.push_back(row_e);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void build_file(scenario_t sc);
    logic [31:0] w, h, ofs, hlen, bpp, comp, bad_dim;
    logic [7:0]  bad;
    int          hdr_end, rows, rowbytes, pad, k;
    bit          is_core, good;
    file_bytes.delete();
    if (sc == SC_NOISE) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
      return;
    end
    good    = (sc == SC_GOOD_INFO || sc == SC_GOOD_CORE);
    is_core = (sc == SC_GOOD_CORE) ||
              ((sc inside {SC_BAD_SIG, SC_BAD_BPP, SC_BAD_OFFSET, SC_BAD_DIM}) &&
               $urandom_range(0, 2) == 0);
    hlen = is_core ? HDR_CORE : HDR_INFO;
    if (sc == SC_HDR_UNSUP) begin
      k    = $urandom_range(0, 2);
      hlen = (k == 0) ? HDR_V2 : (k == 1) ? HDR_V4 : HDR_V5;
    end else if (sc == SC_HDR_UNKNOWN) begin
      do
        hlen = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 130));
      while (hlen == HDR_INFO || hlen == HDR_CORE || hlen == HDR_V2 ||
             hlen == HDR_V4 || hlen == HDR_V5);
    end
    hdr_end = 14 + int'(hlen);

    w = $urandom_range(1, 5);
    h = $urandom_range(1, 3);
    if ($urandom_range(0, 9) == 0) w = $urandom_range(6, 24);
    if ($urandom_range(0, 15) == 0) w = DIM_LIMIT;
    if ($urandom_range(0, 15) == 0) h = DIM_LIMIT;
    if (sc == SC_BAD_DIM) begin
      k = $urandom_range(0, 3);
      if (k == 0) bad_dim = 32'd0;
      else if (k == 1) bad_dim = 32'(DIM_LIMIT + 1);
      else if (is_core) bad_dim = $urandom_range(DIM_LIMIT + 1, 65535);
      else if (k == 2) bad_dim = 32'hFFFF_FFFF;
      else bad_dim = 32'h8000_0000 | 32'($urandom);
      if ($urandom_range(0, 1)) w = bad_dim;
      else h = bad_dim;
    end
    bpp = 32'(BPP_24);
    if (sc == SC_BAD_BPP) begin
      bpp = $urandom_range(0, 65535);
      if (bpp == 32'(BPP_24)) bpp = 32'h0000_1800;
    end
    comp = 32'd0;
    if (sc == SC_BAD_COMP) begin
      comp = $urandom_range(0, 1) ? 32'($urandom_range(1, 3)) : 32'($urandom);
      if (comp == 32'd0) comp = 32'd1;
    end

    ofs = 32'(hdr_end + $urandom_range(0, 5));
    if (sc == SC_BAD_OFFSET)
      ofs = $urandom_range(0, 1) ? 32'(hdr_end - 1) : 32'($urandom_range(0, hdr_end - 1));
    else if (sc == SC_HDR_UNSUP || sc == SC_HDR_UNKNOWN) ofs = $urandom;
    else if (good && $urandom_range(0, 24) == 0) ofs = 32'hFFFF_FFFF;

    if (sc == SC_BAD_SIG) begin
      bad = 8'($urandom);
      k   = $urandom_range(0, 2);
      if (k == 0) begin
        if (bad == SIG_B) bad = ~bad;
        file_bytes.push_back(bad);
        file_bytes.push_back(SIG_M);
      end else if (k == 1) begin
        if (bad == SIG_M) bad = ~bad;
        file_bytes.push_back(SIG_B);
        file_bytes.push_back(bad);
      end else begin
        file_bytes.push_back(SIG_M);
        file_bytes.push_back(SIG_B);
      end
    end else begin
      file_bytes.push_back(SIG_B);
      file_bytes.push_back(SIG_M);
    end
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(ofs, 4);
    put_le(hlen, 4);
    if (hlen != HDR_INFO && hlen != HDR_CORE) begin
      repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
      return;
    end
    if (is_core) begin
      put_le(w, 2);
      put_le(h, 2);
      put_le($urandom, 2);
      put_le(bpp, 2);
    end else begin
      put_le(w, 4);
      put_le(h, 4);
      put_le($urandom, 2);
      put_le(bpp, 2);
      put_le(comp, 4);
      repeat (20) file_bytes.push_back(8'($urandom));
    end
    if (!good) begin
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
      return;
    end
    // never-reached data offset: a few skipped bytes, then the next file cuts in
    if (ofs == 32'hFFFF_FFFF) begin
      repeat ($urandom_range(3, 10)) file_bytes.push_back(8'($urandom));
      return;
    end
    repeat (int'(ofs) - hdr_end) file_bytes.push_back(8'($urandom));
    if (w > 32'd64) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
      return;
    end
    rowbytes = int'(w) * 3;
    pad      = (4 - rowbytes % 4) % 4;
    rows     = (h > 32'd8) ? 2 : int'(h);
    for (k = 0; k < rows; k++) begin
      repeat (rowbytes) file_bytes.push_back(8'($urandom));
      repeat (pad) file_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, rowbytes)) void'(file_bytes.pop_back());
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
  endfunction

  // Offer one beat and hold it until taken; open a random gap between bursts.
  task automatic send_byte(logic [7:0] d, logic s, int row_idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_data_byte     <= d;
    in_start_of_file <= s;
    in_row           <= row_idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    scenario_t first_pass[10];
    scenario_t sc;
    int        f, pick;
    in_valid         <= 1'b0;
    in_data_byte     <= 8'h00;
    in_start_of_file <= 1'b0;
    in_row           <= -1;
    rst_n            <= 1'b0;
    parser_clear();
    first_pass = '{SC_GOOD_INFO, SC_GOOD_CORE, SC_BAD_SIG, SC_BAD_BPP, SC_BAD_COMP,
                   SC_HDR_UNSUP, SC_HDR_UNKNOWN, SC_BAD_OFFSET, SC_BAD_DIM, SC_NOISE};

    // first byte after reset without start_of_file, then a wrong signature
    add_row("Q", 1'b0);
    add_row(SIG_M, 1'b0, 1'b1, error_beat(ERR_SIG));
    add_row(8'h00, 1'b1);
    add_row(8'hFF, 1'b0, 1'b1, error_beat(ERR_SIG));
    // good signature, all-ones size and header length
    add_row(SIG_B, 1'b1);
    add_row(SIG_M, 1'b0);
    repeat (4) add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0);
    repeat (4) add_row(8'h00, 1'b0);
    repeat (3) add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, error_beat(ERR_UNKNOWN));
    // ignored after an error
    add_row(8'h55, 1'b0);
    add_row(8'h00, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].sof, i);
    drain_results();

    f = 0;
    while (live_bytes < ITEM_TARGET) begin
      if (f < 10) begin
        sc = first_pass[f];
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) sc = SC_GOOD_INFO;
        else if (pick < 65) sc = SC_GOOD_CORE;
        else sc = scenario_t'($urandom_range(int'(SC_BAD_SIG), int'(SC_NOISE)));
      end
      if (f == 0) long_hold = 1'b1;
      if (f == 5) drain_results();
      build_file(sc);
      foreach (file_bytes[k]) send_byte(file_bytes[k], k == 0, -1);
      f++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[bmp_24bit_stream_decoder] OK");
    end else begin
      $display("[bmp_24bit_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bmp24_pkg.sv
hdl/bmp24_in_stage.sv
hdl/bmp24_parser.sv
hdl/bmp24_out_stage.sv
hdl/bmp_24bit_stream_decoder.sv
verif/tb_bmp_24bit_stream_decoder.sv
